>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the frame timing monitor.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that the consequent holds in the same cycle as the antecedent.
`define FTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame timing monitor: assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define FTM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame timing monitor: assertion failed");
`else
`define FTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FTM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ftm_pkg.sv
// Types, constants and helper functions for the frame timing monitor.
// No dependencies; used by frame_timing_monitor_top.
package ftm_pkg;

  // Widths of the fixed-size fields and counters.
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int SNAP_W  = 16;
  // A count times 100 needs seven more bits.
  localparam int DSR_W   = CNT_W + 7;

  localparam logic [STAMP_W-1:0] MAX_PERIOD_RST = 32'd250000;
  localparam logic [DSR_W-1:0]   SCALE          = 39'd100;
  localparam logic [SNAP_W-1:0]  SNAP_MAX       = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_PSETUP,
    ST_DLOAD,
    ST_DIV,
    ST_PUBLISH
  } ftm_state_t;

  // Which snapshot value the shared divider is working on.
  typedef enum logic [1:0] {
    DOP_AVG,
    DOP_WORST,
    DOP_PERIOD
  } ftm_div_op_t;

  // Saturate an unsigned value to 16 bits.
  function automatic logic [SNAP_W-1:0] sat16(input logic [63:0] v);
    sat16 = (v > 64'(SNAP_MAX)) ? SNAP_MAX : v[SNAP_W-1:0];
  endfunction

  // Count times 100 as a shift-add: 64 + 32 + 4.
  function automatic logic [DSR_W-1:0] times_scale(input logic [CNT_W-1:0] c);
    logic [DSR_W-1:0] ce;
    ce = DSR_W'(c);
    times_scale = (ce << 6) + (ce << 5) + (ce << 2);
  endfunction

endpackage

>>> rtl/frame_timing_monitor_top.sv
// Frame timing monitor: frame accumulators, shared iterative divider, snapshot.
// Depends on ftm_pkg and assert_macros.svh.
// Frame transfer: accepted in ST_IDLE, accumulators updated in ST_FRAME (in_tready low), then ST_IDLE.
// Publish transfer: a setup step (ST_PSETUP), then up to three divisions (ST_DLOAD, ST_DIV)
// on one restoring divider (one quotient bit per cycle), then ST_PUBLISH loads the output
// once the output register is free; an empty window skips the divisions.
// Synchronous active-low reset clears accumulators, snapshot, out_tvalid; sets max_period to 250000.
`include "assert_macros.svh"

module frame_timing_monitor_top #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: max_period.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_us [31:0], end_us [63:32]
  input  logic [0:0]  in_tuser,   // kind [0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // frames [15:0], avg_us100 [31:16],
                                  // worst_us100 [47:32], period_us100 [63:48]
  output logic [0:0]  out_tuser   // updated [0]
);

  localparam int TW   = TIME_WIDTH;
  localparam int CW   = $clog2(TW);
  localparam int CMPW = (TW > ftm_pkg::STAMP_W) ? TW : ftm_pkg::STAMP_W;
  localparam int DW   = ftm_pkg::DSR_W;
  localparam int SW   = ftm_pkg::SNAP_W;
  localparam int CNW  = ftm_pkg::CNT_W;

  // Sequencer and configuration.
  ftm_pkg::ftm_state_t  state_r, state_nxt;
  ftm_pkg::ftm_div_op_t div_op_r, div_op_nxt;
  logic [31:0]          max_period_r, max_period_nxt;

  // Window accumulators.
  logic [CNW-1:0] fc_r, fc_nxt;
  logic [CNW-1:0] pc_r, pc_nxt;
  logic [TW-1:0]  dsum_r, dsum_nxt;
  logic [TW-1:0]  worst_r, worst_nxt;
  logic [TW-1:0]  last_start_r, last_start_nxt;
  logic [TW-1:0]  psum_r, psum_nxt;

  // Snapshot.
  logic [SW-1:0] snap_frames_r, snap_frames_nxt;
  logic [SW-1:0] snap_avg_r, snap_avg_nxt;
  logic [SW-1:0] snap_worst_r, snap_worst_nxt;
  logic [SW-1:0] snap_period_r, snap_period_nxt;
  logic          upd_r, upd_nxt;

  // Frame item holding registers.
  logic [TW-1:0] t0_r, t0_nxt;
  logic [TW-1:0] dur_r, dur_nxt;
  logic [TW-1:0] per_r, per_nxt;

  // Scaled counts for the divisor.
  logic [DW-1:0] fc100_r, fc100_nxt;
  logic [DW-1:0] pc100_r, pc100_nxt;

  // Shared divider: dividend shifts out at the top while quotient bits shift in.
  logic [TW-1:0] dvd_r, dvd_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_data_r, out_data_nxt;
  logic          out_upd_r, out_upd_nxt;

  // Combinational helpers.
  logic          in_xfer;
  logic [TW-1:0] in_t0;
  logic [TW-1:0] in_t1;
  logic [DW:0]   trial;
  logic          qbit;
  logic [TW-1:0] quot;
  logic [SW-1:0] quot_sat;

  assign in_tready = (state_r == ftm_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_t0     = TW'(in_tdata[31:0]);
  assign in_t1     = TW'(in_tdata[63:32]);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_upd_r;

  // One restoring step of the divider.
  assign trial    = {rem_r, dvd_r[TW-1]};
  assign qbit     = (trial >= {1'b0, dsr_r});
  assign quot     = {dvd_r[TW-2:0], qbit};
  assign quot_sat = ftm_pkg::sat16(64'(quot));

  // Next state and datapath control.
  always_comb begin
    state_nxt       = state_r;
    div_op_nxt      = div_op_r;
    max_period_nxt  = max_period_r;
    fc_nxt          = fc_r;
    pc_nxt          = pc_r;
    dsum_nxt        = dsum_r;
    worst_nxt       = worst_r;
    last_start_nxt  = last_start_r;
    psum_nxt        = psum_r;
    snap_frames_nxt = snap_frames_r;
    snap_avg_nxt    = snap_avg_r;
    snap_worst_nxt  = snap_worst_r;
    snap_period_nxt = snap_period_r;
    upd_nxt         = upd_r;
    t0_nxt          = t0_r;
    dur_nxt         = dur_r;
    per_nxt         = per_r;
    fc100_nxt       = fc100_r;
    pc100_nxt       = pc100_r;
    dvd_nxt         = dvd_r;
    dsr_nxt         = dsr_r;
    rem_nxt         = rem_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_upd_nxt     = out_upd_r;

    if (cfg_wr_en) begin
      max_period_nxt = cfg_wr_data;
    end

    // The result leaves on a completed output transfer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ftm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser[0]) begin
            state_nxt = ftm_pkg::ST_PSETUP;
          end else begin
            // Duration and period are taken while the stamps are on the port.
            t0_nxt    = in_t0;
            dur_nxt   = in_t1 - in_t0;
            per_nxt   = in_t0 - last_start_r;
            state_nxt = ftm_pkg::ST_FRAME;
          end
        end
      end

      ftm_pkg::ST_FRAME: begin
        fc_nxt   = fc_r + CNW'(1);
        dsum_nxt = dsum_r + dur_r;
        if (dur_r > worst_r) begin
          worst_nxt = dur_r;
        end
        // A zero last start means no start is on record yet.
        if ((last_start_r != '0) && (CMPW'(per_r) < CMPW'(max_period_r))) begin
          psum_nxt = psum_r + per_r;
          pc_nxt   = pc_r + CNW'(1);
        end
        last_start_nxt = t0_r;
        state_nxt      = ftm_pkg::ST_IDLE;
      end

      ftm_pkg::ST_PSETUP: begin
        fc100_nxt = ftm_pkg::times_scale(fc_r);
        pc100_nxt = ftm_pkg::times_scale(pc_r);
        if (fc_r != '0) begin
          // The window has frames: refresh the snapshot.
          upd_nxt         = 1'b1;
          snap_frames_nxt = ftm_pkg::sat16(64'(fc_r));
          div_op_nxt      = ftm_pkg::DOP_AVG;
          state_nxt       = ftm_pkg::ST_DLOAD;
        end else begin
          // Empty window: keep the previous snapshot.
          upd_nxt   = 1'b0;
          state_nxt = ftm_pkg::ST_PUBLISH;
        end
      end

      ftm_pkg::ST_DLOAD: begin
        // Dividing by 100 times the count gives the average over 100 in one pass.
        rem_nxt   = '0;
        cnt_nxt   = CW'(TW - 1);
        state_nxt = ftm_pkg::ST_DIV;
        unique case (div_op_r)
          ftm_pkg::DOP_AVG: begin
            dvd_nxt = dsum_r;
            dsr_nxt = fc100_r;
          end
          ftm_pkg::DOP_WORST: begin
            dvd_nxt = worst_r;
            dsr_nxt = ftm_pkg::SCALE;
          end
          ftm_pkg::DOP_PERIOD: begin
            dvd_nxt = psum_r;
            dsr_nxt = pc100_r;
          end
          default: begin
            state_nxt = ftm_pkg::ST_PUBLISH;
          end
        endcase
      end

      ftm_pkg::ST_DIV: begin
        rem_nxt = qbit ? DW'(trial - {1'b0, dsr_r}) : trial[DW-1:0];
        dvd_nxt = quot;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          unique case (div_op_r)
            ftm_pkg::DOP_AVG: begin
              snap_avg_nxt = quot_sat;
              div_op_nxt   = ftm_pkg::DOP_WORST;
              state_nxt    = ftm_pkg::ST_DLOAD;
            end
            ftm_pkg::DOP_WORST: begin
              snap_worst_nxt = quot_sat;
              if (pc_r != '0) begin
                div_op_nxt = ftm_pkg::DOP_PERIOD;
                state_nxt  = ftm_pkg::ST_DLOAD;
              end else begin
                // No period was accepted in this window.
                snap_period_nxt = '0;
                state_nxt       = ftm_pkg::ST_PUBLISH;
              end
            end
            ftm_pkg::DOP_PERIOD: begin
              snap_period_nxt = quot_sat;
              state_nxt       = ftm_pkg::ST_PUBLISH;
            end
            default: begin
              state_nxt = ftm_pkg::ST_PUBLISH;
            end
          endcase
        end
      end

      ftm_pkg::ST_PUBLISH: begin
        // Wait until the output register is free, then load it and clear the window.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = {snap_period_r, snap_worst_r, snap_avg_r, snap_frames_r};
          out_upd_nxt    = upd_r;
          fc_nxt         = '0;
          pc_nxt         = '0;
          dsum_nxt       = '0;
          worst_nxt      = '0;
          last_start_nxt = '0;
          psum_nxt       = '0;
          state_nxt      = ftm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ftm_pkg::ST_IDLE;
      end
    endcase
  end

  // Registers with reset: control, configuration, accumulators and snapshot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ftm_pkg::ST_IDLE;
      div_op_r      <= ftm_pkg::DOP_AVG;
      max_period_r  <= ftm_pkg::MAX_PERIOD_RST;
      fc_r          <= '0;
      pc_r          <= '0;
      dsum_r        <= '0;
      worst_r       <= '0;
      last_start_r  <= '0;
      psum_r        <= '0;
      snap_frames_r <= '0;
      snap_avg_r    <= '0;
      snap_worst_r  <= '0;
      snap_period_r <= '0;
      upd_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      div_op_r      <= div_op_nxt;
      max_period_r  <= max_period_nxt;
      fc_r          <= fc_nxt;
      pc_r          <= pc_nxt;
      dsum_r        <= dsum_nxt;
      worst_r       <= worst_nxt;
      last_start_r  <= last_start_nxt;
      psum_r        <= psum_nxt;
      snap_frames_r <= snap_frames_nxt;
      snap_avg_r    <= snap_avg_nxt;
      snap_worst_r  <= snap_worst_nxt;
      snap_period_r <= snap_period_nxt;
      upd_r         <= upd_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    t0_r       <= t0_nxt;
    dur_r      <= dur_nxt;
    per_r      <= per_nxt;
    fc100_r    <= fc100_nxt;
    pc100_r    <= pc100_nxt;
    dvd_r      <= dvd_nxt;
    dsr_r      <= dsr_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  // The divider never runs on a zero divisor.
  `FTM_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_r == ftm_pkg::ST_DIV, dsr_r != '0)
  // The partial remainder always stays below the divisor.
  `FTM_ASSERT_IMP(a_rem_bound, clk, rst_n, state_r == ftm_pkg::ST_DIV, rem_r < dsr_r)
  // A new result appears only from the publish step.
  `FTM_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == ftm_pkg::ST_PUBLISH)
  // Leaving the publish step leaves an empty window behind.
  `FTM_ASSERT_NXT(a_pub_clear, clk, rst_n,
    (state_r == ftm_pkg::ST_PUBLISH) && (state_nxt == ftm_pkg::ST_IDLE),
    (fc_r == '0) && (pc_r == '0) && (last_start_r == '0))

endmodule
